@@ hdl/parcor_lattice_filter_defines.svh @@
// Assertion helpers for the lattice filter RTL.
`ifndef PARCOR_LATTICE_FILTER_DEFINES_SVH
`define PARCOR_LATTICE_FILTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PLF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PLF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/plf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package plf_pkg;

    // Field widths
    localparam int DATA_W     = 32;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = DATA_W + COEF_W;
    localparam int IDX_W      = 6;
    localparam int ORDER_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Q15 rounding
    localparam int Q_SHIFT    = 15;
    localparam int ROUND_HALF = 1 << (Q_SHIFT - 1);

    // Request codes
    localparam logic REQ_COEF   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;

    typedef enum logic {
        MODE_ANALYSIS  = 1'b0,
        MODE_SYNTHESIS = 1'b1
    } t_mode;

    // Backward store write data select
    typedef enum logic {
        WR_DIFF = 1'b0,
        WR_FWD  = 1'b1
    } t_wr_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;      // take sample into forward register
        logic    kwr;       // coefficient table write
        logic    rd_en;     // read backward store and coefficient table
        logic    mul_en;    // capture product
        logic    mul_mem;   // multiply memory read data, else held operands
        logic    cap;       // hold coefficient and backward value
        logic    f_upd;     // update forward value
        logic    f_sub;     // subtract (analysis) instead of add
        logic    wr_en;     // backward store write
        t_wr_sel wr_sel;
        logic    out_load;  // load result register
    } t_dp_cmd;

    // (k*v + 2^14) >>> 15, low DATA_W bits
    function automatic logic [DATA_W-1:0] stage_round(input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W:0] sum;
        sum = {prod[PROD_W-1], prod} + (PROD_W + 1)'(ROUND_HALF);
        return sum[Q_SHIFT +: DATA_W];
    endfunction

endpackage

`default_nettype wire

@@ hdl/plf_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Input items: coefficient writes and samples
interface plf_in_if;
    import plf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [DATA_W-1:0] sample;
    logic                     block_end;

    modport source (output valid, req_type, coef_index, coef_value, sample, block_end,
                    input ready);
    modport sink   (input valid, req_type, coef_index, coef_value, sample, block_end,
                    output ready);
endinterface

// Result items
interface plf_out_if;
    import plf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result;
    logic                     result_last;

    modport source (output valid, result, result_last, input ready);
    modport sink   (input valid, result, result_last, output ready);
endinterface

// Configuration register writes
interface plf_cfg_if;
    import plf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/plf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module plf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hdl/plf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "parcor_lattice_filter_defines.svh"

module plf_ctrl #(
    parameter int MAX_STAGES = 32,
    localparam int AW = $clog2(MAX_STAGES + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_req_type,
    input  logic [plf_pkg::IDX_W-1:0]       i_coef_index,
    input  logic                            i_cfg_valid,
    input  logic [plf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [plf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    output plf_pkg::t_dp_cmd                o_cmd,
    output logic [AW-1:0]                   o_rd_addr,
    output logic [AW-1:0]                   o_wr_addr,
    output logic [AW-1:0]                   o_kwr_addr
);

    import plf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_P0    = 7'b0000100,
        S_P1    = 7'b0001000,
        S_P2    = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_stage, n_stage;
    logic                 r_out_valid, n_out_valid;
    logic [ORDER_W-1:0]   r_order;
    t_mode                r_mode;
    logic [AW-1:0]        order_eff;
    logic                 accept;
    logic                 out_free;
    logic                 idx_ok;
    t_dp_cmd              cmd;

    // Order above the table size acts as the maximum
    assign order_eff = (r_order > MAX_STAGES) ? AW'(MAX_STAGES) : AW'(r_order);

    // No input transfer while reset is held
    assign o_in_ready = i_rst_n && (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign idx_ok     = (i_coef_index != '0) && (i_coef_index <= MAX_STAGES);
    assign o_kwr_addr = AW'(i_coef_index);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= '0;
            r_mode  <= MODE_ANALYSIS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORDER: r_order <= i_cfg_data[ORDER_W-1:0];
                CFG_MODE:  r_mode  <= t_mode'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    // Sequencer: analysis runs stages upward in two steps each,
    // synthesis runs them downward in three steps each
    always_comb begin
        n_state   = r_state;
        n_stage   = r_stage;
        cmd       = '0;
        o_rd_addr = '0;
        o_wr_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_req_type == REQ_SAMPLE) begin
                        cmd.load = 1'b1;
                        n_state  = S_START;
                    end else begin
                        cmd.kwr = idx_ok;
                    end
                end
            end
            S_START: begin
                if (order_eff == '0) begin
                    // pass-through: backward entry 0 takes the sample
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_FWD;
                    n_state    = S_DONE;
                end else begin
                    cmd.rd_en = 1'b1;
                    if (r_mode == MODE_ANALYSIS) begin
                        o_rd_addr = '0;
                        n_stage   = AW'(1);
                    end else begin
                        o_rd_addr = order_eff - AW'(1);
                        n_stage   = order_eff;
                    end
                    n_state = S_P0;
                end
            end
            S_P0: begin
                // multiply k[s] by old b[s-1]; retire previous stage's write
                cmd.mul_en  = 1'b1;
                cmd.mul_mem = 1'b1;
                cmd.cap     = 1'b1;
                if (r_mode == MODE_ANALYSIS) begin
                    cmd.wr_en  = 1'b1;
                    o_wr_addr  = r_stage - AW'(1);
                    cmd.wr_sel = (r_stage == AW'(1)) ? WR_FWD : WR_DIFF;
                    cmd.rd_en  = (r_stage < order_eff);
                    o_rd_addr  = r_stage;
                end else begin
                    cmd.wr_en  = (r_stage < order_eff);
                    o_wr_addr  = r_stage + AW'(1);
                    cmd.wr_sel = WR_DIFF;
                    cmd.rd_en  = (r_stage > AW'(1));
                    o_rd_addr  = r_stage - AW'(2);
                end
                n_state = S_P1;
            end
            S_P1: begin
                cmd.f_upd = 1'b1;
                if (r_mode == MODE_ANALYSIS) begin
                    // forward update and k[s] * old forward value together
                    cmd.f_sub  = 1'b1;
                    cmd.mul_en = 1'b1;
                    if (r_stage == order_eff) begin
                        n_state = S_FIN;
                    end else begin
                        n_stage = r_stage + AW'(1);
                        n_state = S_P0;
                    end
                end else begin
                    n_state = S_P2;
                end
            end
            S_P2: begin
                // synthesis: k[s] * new forward value
                cmd.mul_en = 1'b1;
                if (r_stage == AW'(1)) begin
                    cmd.wr_en  = 1'b1;
                    o_wr_addr  = '0;
                    cmd.wr_sel = WR_FWD;
                    n_state    = S_FIN;
                end else begin
                    n_stage = r_stage - AW'(1);
                    n_state = S_P0;
                end
            end
            S_FIN: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_DIFF;
                o_wr_addr  = (r_mode == MODE_ANALYSIS) ? order_eff : AW'(1);
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output slot: loaded from the datapath, freed by an output transfer
    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stage     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    `PLF_ASSERT_IMP(a_rw_apart, i_clk, i_rst_n, cmd.rd_en && cmd.wr_en,
        o_rd_addr != o_wr_addr, "backward store read and write hit one entry")
    `PLF_ASSERT_IMP(a_stage_range, i_clk, i_rst_n,
        r_state == S_P0 || r_state == S_P1 || r_state == S_P2,
        r_stage != '0 && r_stage <= order_eff, "stage counter out of range")
    `PLF_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, cmd.out_load,
        !r_out_valid || i_out_ready, "result register overwritten")
    `PLF_ASSERT_NXT(a_last_stage, i_clk, i_rst_n, r_state == S_P2 && r_stage == AW'(1),
        r_state == S_FIN, "synthesis did not finish after first stage")

endmodule

`default_nettype wire

@@ hdl/plf_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module plf_datapath #(
    parameter int MAX_STAGES = 32,
    localparam int AW = $clog2(MAX_STAGES + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  plf_pkg::t_dp_cmd                  i_cmd,
    input  logic [AW-1:0]                     i_rd_addr,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic [AW-1:0]                     i_kwr_addr,
    input  logic signed [plf_pkg::COEF_W-1:0] i_coef_value,
    input  logic signed [plf_pkg::DATA_W-1:0] i_sample,
    input  logic                              i_block_end,
    output logic signed [plf_pkg::DATA_W-1:0] o_result,
    output logic                              o_result_last
);

    import plf_pkg::*;

    localparam int DEPTH = MAX_STAGES + 1;

    logic [AW-1:0]            k_rd_addr;
    logic [DATA_W-1:0]        b_ram_q;
    logic [COEF_W-1:0]        k_ram_q;
    logic [DEPTH-1:0]         r_b_valid;
    logic [DEPTH-1:0]         r_k_valid;
    logic                     r_b_rd_valid;
    logic                     r_k_rd_valid;
    logic signed [DATA_W-1:0] b_rd;
    logic signed [COEF_W-1:0] k_rd;
    logic signed [COEF_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DATA_W-1:0] rnd;
    logic signed [DATA_W-1:0] diff;
    logic signed [DATA_W-1:0] wr_data;
    logic signed [DATA_W-1:0] r_fwd;
    logic signed [DATA_W-1:0] r_bprev;
    logic signed [COEF_W-1:0] r_k;
    logic                     r_last;
    logic signed [DATA_W-1:0] r_result;
    logic                     r_result_last;

    // Coefficient k[s] sits one entry above backward value b[s-1]
    assign k_rd_addr = i_rd_addr + AW'(1);

    plf_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_bwd_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (b_ram_q)
    );

    plf_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_coef_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.kwr),
        .i_wr_addr (i_kwr_addr),
        .i_wr_data (i_coef_value),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (k_rd_addr),
        .o_rd_data (k_ram_q)
    );

    // Per-entry valid bits: unwritten entries read as zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid    <= '0;
            r_k_valid    <= '0;
            r_b_rd_valid <= 1'b0;
            r_k_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_b_valid[i_wr_addr] <= 1'b1;
            end
            if (i_cmd.kwr) begin
                r_k_valid[i_kwr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_b_rd_valid <= r_b_valid[i_rd_addr];
                r_k_rd_valid <= r_k_valid[k_rd_addr];
            end
        end
    end

    assign b_rd = r_b_rd_valid ? $signed(b_ram_q) : '0;
    assign k_rd = r_k_rd_valid ? $signed(k_ram_q) : '0;

    // Shared 16x32 multiplier
    assign mul_a   = i_cmd.mul_mem ? k_rd : r_k;
    assign mul_b   = i_cmd.mul_mem ? b_rd : r_fwd;
    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Rounded stage term and backward difference
    assign rnd     = stage_round(r_prod);
    assign diff    = r_bprev - rnd;
    assign wr_data = (i_cmd.wr_sel == WR_FWD) ? r_fwd : diff;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fwd  <= i_sample;
            r_last <= i_block_end;
        end else if (i_cmd.f_upd) begin
            r_fwd <= i_cmd.f_sub ? (r_fwd - rnd) : (r_fwd + rnd);
        end
        if (i_cmd.mul_en) begin
            r_prod <= product;
        end
        if (i_cmd.cap) begin
            r_k     <= k_rd;
            r_bprev <= b_rd;
        end
        if (i_cmd.out_load) begin
            r_result      <= r_fwd;
            r_result_last <= r_last;
        end
    end

    assign o_result      = r_result;
    assign o_result_last = r_result_last;

endmodule

`default_nettype wire

@@ hdl/parcor_lattice_filter.sv @@
// Each sample runs through the stages of the order in use, upward in analysis mode and
// downward in synthesis mode; order zero passes the sample straight through.
// Input items are taken only while the sequencer is idle, so a sample is finished before
// another item is taken; the one shared 16x32 multiplier is used twice by each stage.
// Reset (i_rst_n, synchronous, active low) clears the sequencer, both configuration registers
// and the valid bits of the backward and coefficient stores, which then read zero at once.
`timescale 1ns / 1ps
`default_nettype none

module parcor_lattice_filter #(
    parameter int MAX_STAGES = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    plf_in_if.sink   i_in,
    plf_out_if.source o_out,
    plf_cfg_if.sink  i_cfg
);

    import plf_pkg::*;

    localparam int AW = $clog2(MAX_STAGES + 1);

    t_dp_cmd       cmd;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] kwr_addr;

    // Configuration writes are taken whenever out of reset
    assign i_cfg.ready = i_rst_n;

    // Sequencer and configuration
    plf_ctrl #(.MAX_STAGES(MAX_STAGES)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_req_type (i_in.req_type),
        .i_coef_index  (i_in.coef_index),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_out.ready),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid),
        .o_cmd         (cmd),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_kwr_addr    (kwr_addr)
    );

    // Stores, multiplier and lattice registers
    plf_datapath #(.MAX_STAGES(MAX_STAGES)) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rd_addr     (rd_addr),
        .i_wr_addr     (wr_addr),
        .i_kwr_addr    (kwr_addr),
        .i_coef_value  (i_in.coef_value),
        .i_sample      (i_in.sample),
        .i_block_end   (i_in.block_end),
        .o_result      (o_out.result),
        .o_result_last (o_out.result_last)
    );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import plf_pkg::*;

    localparam int MAX_STAGES    = 32;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int ITEM_GOAL     = 1550;
    localparam int SETTLE_CYCLES = 3 * MAX_STAGES + 20;
    localparam int IDLE_MAX      = 13;
    localparam int HOLD_CYCLES   = 600;

    typedef struct packed {
        logic                     req_type;
        logic [IDX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [DATA_W-1:0] sample;
        logic                     block_end;
    } t_lattice_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     last;
    } t_lattice_out;

    // Lattice predictor plus the queue of results still owed by the block
    class lattice_scoreboard;
        logic [DATA_W-1:0]        bwd_store [0:MAX_STAGES];
        logic signed [COEF_W-1:0] refl_coef [0:MAX_STAGES];
        logic [ORDER_W-1:0]       order_reg;
        t_mode                    mode_reg;
        t_lattice_out             expected_results [$];
        int unsigned              n_fail;

        function new();
            foreach (bwd_store[i]) bwd_store[i] = '0;
            foreach (refl_coef[i]) refl_coef[i] = '0;
            order_reg = '0;
            mode_reg  = MODE_ANALYSIS;
            n_fail    = 0;
        endfunction

        // k * v in Q15: full-width product, add half LSB, arithmetic shift, keep low word
        function logic [DATA_W-1:0] q15_scale(logic signed [COEF_W-1:0] k,
                                              logic [DATA_W-1:0] v);
            logic signed [PROD_W-1:0] prod;
            prod = k * $signed(v);
            prod = prod + PROD_W'(ROUND_HALF);
            return prod[Q_SHIFT +: DATA_W];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_ORDER)
                order_reg = value;
            else if (idx == CFG_MODE)
                mode_reg = t_mode'(value[0]);
        endfunction

        // Called on every accepted input transfer
        function void note_item(t_lattice_in it);
            logic [DATA_W-1:0] fwd [0:MAX_STAGES];
            logic [DATA_W-1:0] acc;
            int                stages;
            t_lattice_out      res;
            if (it.req_type == REQ_COEF) begin
                // out-of-range stage indexes are dropped
                if (it.coef_index >= 1 && it.coef_index <= MAX_STAGES)
                    refl_coef[it.coef_index] = it.coef_value;
                return;
            end
            stages = (order_reg > MAX_STAGES) ? MAX_STAGES : int'(order_reg);
            if (mode_reg == MODE_ANALYSIS) begin
                fwd[0] = it.sample;
                for (int s = 1; s <= stages; s++)
                    fwd[s] = fwd[s-1] - q15_scale(refl_coef[s], bwd_store[s-1]);
                for (int s = stages; s >= 1; s--)
                    bwd_store[s] = bwd_store[s-1] - q15_scale(refl_coef[s], fwd[s-1]);
                bwd_store[0] = it.sample;
                acc = fwd[stages];
            end else begin
                acc = it.sample;
                for (int s = stages; s >= 1; s--) begin
                    acc = acc + q15_scale(refl_coef[s], bwd_store[s-1]);
                    bwd_store[s] = bwd_store[s-1] - q15_scale(refl_coef[s], acc);
                end
                bwd_store[0] = acc;
            end
            res.result = acc;
            res.last   = it.block_end;
            expected_results.push_back(res);
        endfunction

        // Called on every accepted output transfer
        function void check_result(logic signed [DATA_W-1:0] value, logic last);
            t_lattice_out exp_res;
            if (expected_results.size() == 0) begin
                $error("result with no sample pending: result=%0d result_last=%0b",
                       value, last);
                n_fail++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (value !== exp_res.result) begin
                $error("result: expected %0d (0x%08h), actual %0d (0x%08h)",
                       exp_res.result, exp_res.result, value, value);
                n_fail++;
            end
            if (last !== exp_res.last) begin
                $error("result_last: expected %0b, actual %0b", exp_res.last, last);
                n_fail++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    plf_in_if  in_if ();
    plf_out_if out_if ();
    plf_cfg_if cfg_if ();

    parcor_lattice_filter #(
        .MAX_STAGES (MAX_STAGES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    lattice_scoreboard sb = new();

    bit          idle_off;
    int          hold_cycles;
    int          items_sent;
    int unsigned cycle_cnt;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt, sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.result, out_if.result_last);
    end

    // Result receiver: random stalls per result, long hold-off on request
    initial begin
        int unsigned gap;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                out_if.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            gap = idle_off ? 0 : $urandom_range(0, IDLE_MAX);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    function automatic t_lattice_in make_coef(logic [IDX_W-1:0] idx,
                                              logic signed [COEF_W-1:0] value);
        t_lattice_in it;
        it.req_type   = REQ_COEF;
        it.coef_index = idx;
        it.coef_value = value;
        it.sample     = $urandom;
        it.block_end  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_lattice_in make_sample(logic signed [DATA_W-1:0] x, logic last);
        t_lattice_in it;
        it.req_type   = REQ_SAMPLE;
        it.coef_index = IDX_W'($urandom);
        it.coef_value = COEF_W'($urandom);
        it.sample     = x;
        it.block_end  = last;
        return it;
    endfunction

    // Mix of full-range words, audio-sized values and the extremes
    function automatic logic signed [DATA_W-1:0] rand_sample();
        logic signed [15:0] narrow;
        logic signed [23:0] mid;
        narrow = 16'($urandom);
        mid    = 24'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return DATA_W'(narrow);
            7: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7FFF_FFFF;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default:    return DATA_W'(mid);
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0, 1:    return COEF_W'($urandom);
            2, 3, 4: return COEF_W'(int'($urandom_range(0, 58000)) - 29000);
            default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    // Offer one input item and wait for its transfer
    task automatic send_item(input t_lattice_in it);
        int unsigned gap;
        gap = idle_off ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.req_type   <= it.req_type;
        in_if.coef_index <= it.coef_index;
        in_if.coef_value <= it.coef_value;
        in_if.sample     <= it.sample;
        in_if.block_end  <= it.block_end;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_item(it);
        if (!(it.req_type == REQ_COEF && (it.coef_index == 0 || it.coef_index > MAX_STAGES)))
            items_sent++;
    endtask

    // Stop offering, let all results drain, then give a trailing coefficient write time
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, value);
    endtask

    // Both registers are rewritten, always with the filter idle
    task automatic set_config(input logic [ORDER_W-1:0] order, input t_mode mode,
                              input logic [CFG_DATA_W-2:0] pad);
        wait_idle();
        cfg_write(CFG_ORDER, order);
        cfg_write(CFG_MODE, {pad, mode});
        cfg_if.valid <= 1'b0;
    endtask

    // Stimulus
    initial begin
        logic [ORDER_W-1:0] ord;
        t_mode              mode;
        int                 stages;
        int                 n_samples;
        int                 phase;

        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.req_type   <= REQ_COEF;
        in_if.coef_index <= '0;
        in_if.coef_value <= '0;
        in_if.sample     <= '0;
        in_if.block_end  <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= CFG_ORDER;
        cfg_if.data      <= '0;
        idle_off    = 1'b0;
        hold_cycles = 0;
        items_sent  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset config: order zero passes samples straight through
        send_item(make_sample(32'sh8000_0000, 1'b0));
        send_item(make_sample(32'sh7FFF_FFFF, 1'b1));
        send_item(make_sample(-32'sd1, 1'b0));

        // Coefficient table: out-of-range stages are ignored, extremes stored
        send_item(make_coef(6'd0, 16'sh7FFF));
        send_item(make_coef(6'd33, 16'sh1234));
        send_item(make_coef(6'd63, 16'sh8000));
        send_item(make_coef(6'd1, 16'sh8000));
        send_item(make_coef(6'd2, 16'sh7FFF));
        send_item(make_coef(6'd32, 16'sh4000));
        send_item(make_coef(6'd3, 16'sh8001));

        // Two-stage analysis with full-scale samples to force wrapping
        set_config(6'd2, MODE_ANALYSIS, '0);
        send_item(make_sample(32'sh7FFF_FFFF, 1'b0));
        send_item(make_sample(32'sh8000_0000, 1'b0));
        send_item(make_sample(32'sh7FFF_FFFF, 1'b0));
        send_item(make_sample(32'sh0000_0000, 1'b0));
        send_item(make_sample(32'sh0000_0001, 1'b1));

        // Switch mode without clearing the backward store
        set_config(6'd2, MODE_SYNTHESIS, '0);
        send_item(make_sample(32'sh8000_0000, 1'b0));
        send_item(make_sample(32'sh7FFF_FFFF, 1'b0));
        send_item(make_sample(32'sh1234_5678, 1'b1));

        // Orders above the maximum clamp to it
        set_config(6'd63, MODE_SYNTHESIS, '0);
        send_item(make_sample(32'sh7FFF_FFFF, 1'b0));
        send_item(make_sample(32'sh8000_0000, 1'b1));
        set_config(6'd33, MODE_ANALYSIS, '0);
        send_item(make_sample(32'sh7FFF_FFFF, 1'b0));
        send_item(make_sample(32'sh8000_0000, 1'b1));
        set_config(6'd32, MODE_ANALYSIS, '0);
        send_item(make_sample(32'sh4000_0000, 1'b1));

        // Random phases: new config, mostly a full coefficient set, then a sample run
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            case ($urandom_range(0, 7))
                0:       ord = '0;
                1, 2:    ord = ORDER_W'($urandom_range(1, 4));
                3, 4:    ord = ORDER_W'($urandom_range(5, MAX_STAGES - 1));
                5:       ord = ORDER_W'(MAX_STAGES);
                6:       ord = ORDER_W'($urandom_range(MAX_STAGES + 1, 63));
                default: ord = ORDER_W'($urandom_range(0, 63));
            endcase
            mode     = t_mode'($urandom_range(0, 1));
            idle_off = ($urandom_range(0, 4) == 0);
            set_config(ord, mode, (CFG_DATA_W - 1)'($urandom));

            // back-pressure: receiver holds off while the sender keeps pushing
            if (phase == 2 || phase == 9) begin
                idle_off    = 1'b1;
                hold_cycles = HOLD_CYCLES;
            end

            stages = (ord > MAX_STAGES) ? MAX_STAGES : int'(ord);
            if ($urandom_range(0, 3) != 0) begin
                for (int s = 1; s <= stages; s++)
                    send_item(make_coef(IDX_W'(s), rand_coef()));
            end

            n_samples = $urandom_range(20, 60);
            for (int n = 0; n < n_samples; n++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(make_coef(IDX_W'($urandom_range(0, 63)), rand_coef()));
                else
                    send_item(make_sample(rand_sample(), $urandom_range(0, 15) == 0));
            end
            phase++;
        end

        // Drain and watch for stray results
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.n_fail == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
